// ----- hw/rtl/ptq_pkg.sv -----
// Package for the pooled task queue with zone search.
// Field widths, opcodes, status codes, entry roles and controller/datapath structs.
// No dependencies.
package ptq_pkg;

    // Field widths
    localparam int OP_W   = 3;
    localparam int POS_W  = 16;
    localparam int TILE_W = 8;
    localparam int ID_W   = 6;
    localparam int ZN_W   = 12;
    localparam int ST_W   = 2;

    // Parameter defaults
    localparam int CAPACITY_DEF  = 64;
    localparam int ZONE_SIDE_DEF = 16;

    // Opcodes
    localparam logic [OP_W-1:0] OP_ADD     = 3'd0;
    localparam logic [OP_W-1:0] OP_TAKE    = 3'd1;
    localparam logic [OP_W-1:0] OP_ZONE    = 3'd2;
    localparam logic [OP_W-1:0] OP_RELEASE = 3'd3;
    localparam logic [OP_W-1:0] OP_REMOVE  = 3'd4;
    localparam logic [OP_W-1:0] OP_FIND    = 3'd5;
    localparam logic [OP_W-1:0] OP_READ    = 3'd6;

    // Status codes
    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL     = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY    = 2'd2;
    localparam logic [ST_W-1:0] ST_NOTFOUND = 2'd3;

    // Entry roles
    localparam logic [1:0] ROLE_FREE   = 2'd0;
    localparam logic [1:0] ROLE_QUEUED = 2'd1;
    localparam logic [1:0] ROLE_OWNED  = 2'd2;

    // Shared memory read address select
    localparam logic [2:0] RD_CUR  = 3'd0;
    localparam logic [2:0] RD_FREE = 3'd1;
    localparam logic [2:0] RD_HEAD = 3'd2;
    localparam logic [2:0] RD_ID   = 3'd3;
    localparam logic [2:0] RD_NEXT = 3'd4;

    // Controller to datapath commands
    typedef struct packed {
        logic            latch;
        logic [2:0]      rd_sel;
        logic            walk_start;
        logic            walk_step;
        logic            cur_id;
        logic            add_commit;
        logic            add_link;
        logic            unlink;
        logic            own_cur;
        logic            free_cur;
        logic            set_status;
        logic [ST_W-1:0] status;
        logic            out_load;
    } ptq_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            full;
        logic            head_nil;
        logic            id_bad;
        logic            used_zero;
        logic            role_owned;
        logic            role_queued;
        logic            match;
        logic            walk_end;
        logic            out_busy;
    } ptq_stat_t;

endpackage

// ----- hw/rtl/ptq_req_if.sv -----
// Request channel interface: valid/ready plus one operation's fields.
// Depends on ptq_pkg.
interface ptq_req_if;
    import ptq_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          opcode;
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic [TILE_W-1:0]        tile;
    logic [ID_W-1:0]          entry_id;
    logic signed [ZN_W-1:0]   zone_x;
    logic signed [ZN_W-1:0]   zone_y;

    modport source (output valid, opcode, pos_x, pos_y, tile, entry_id, zone_x, zone_y,
                    input ready);
    modport sink   (input valid, opcode, pos_x, pos_y, tile, entry_id, zone_x, zone_y,
                    output ready);
endinterface

// ----- hw/rtl/ptq_rsp_if.sv -----
// Response channel interface: valid/ready plus one result's fields.
// Depends on ptq_pkg.
interface ptq_rsp_if;
    import ptq_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [ST_W-1:0]          status;
    logic [ID_W-1:0]          result_id;
    logic signed [POS_W-1:0]  result_x;
    logic signed [POS_W-1:0]  result_y;
    logic [TILE_W-1:0]        result_tile;

    modport source (output valid, status, result_id, result_x, result_y, result_tile,
                    input ready);
    modport sink   (input valid, status, result_id, result_x, result_y, result_tile,
                    output ready);
endinterface

// ----- hw/rtl/pooled_task_queue_with_zone_search.sv -----
// Top level of the pooled task queue with zone search.
// Depends on ptq_pkg, ptq_req_if, ptq_rsp_if, ptq_ctrl and ptq_datapath.
//
// One operation is taken at a time on req and gives exactly one transaction on rsp.
// Zone search, remove and find walk the queue from the head at one entry per cycle
// through the link memory's single read port; remove first checks the entry's role.
// A new operation is taken once the previous result is loaded into the output
// register, while that result may still wait to be taken. No clearing pass after reset.
module pooled_task_queue_with_zone_search #(
    parameter int CAPACITY  = ptq_pkg::CAPACITY_DEF,
    parameter int ZONE_SIDE = ptq_pkg::ZONE_SIDE_DEF
) (
    input  logic    clk,
    input  logic    rst_n,
    ptq_req_if.sink req,
    ptq_rsp_if.source rsp
);
    import ptq_pkg::*;

    ptq_cmd_t  cmd;
    ptq_stat_t stat;

    ptq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    ptq_datapath #(
        .CAPACITY  (CAPACITY),
        .ZONE_SIDE (ZONE_SIDE)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .opcode      (req.opcode),
        .pos_x       (req.pos_x),
        .pos_y       (req.pos_y),
        .tile        (req.tile),
        .entry_id    (req.entry_id),
        .zone_x      (req.zone_x),
        .zone_y      (req.zone_y),
        .rsp_ready   (rsp.ready),
        .rsp_valid   (rsp.valid),
        .status      (rsp.status),
        .result_id   (rsp.result_id),
        .result_x    (rsp.result_x),
        .result_y    (rsp.result_y),
        .result_tile (rsp.result_tile)
    );

endmodule

// ----- hw/rtl/ptq_datapath.sv -----
// Datapath: entry memories, list pointers, walk registers and result register.
// Depends on ptq_pkg; driven by ptq_ctrl through ptq_cmd_t.
module ptq_datapath #(
    parameter int CAPACITY  = ptq_pkg::CAPACITY_DEF,
    parameter int ZONE_SIDE = ptq_pkg::ZONE_SIDE_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  ptq_pkg::ptq_cmd_t              cmd,
    output ptq_pkg::ptq_stat_t             stat,
    input  logic [ptq_pkg::OP_W-1:0]       opcode,
    input  logic [ptq_pkg::POS_W-1:0]      pos_x,
    input  logic [ptq_pkg::POS_W-1:0]      pos_y,
    input  logic [ptq_pkg::TILE_W-1:0]     tile,
    input  logic [ptq_pkg::ID_W-1:0]       entry_id,
    input  logic [ptq_pkg::ZN_W-1:0]       zone_x,
    input  logic [ptq_pkg::ZN_W-1:0]       zone_y,
    input  logic                           rsp_ready,
    output logic                           rsp_valid,
    output logic [ptq_pkg::ST_W-1:0]       status,
    output logic [ptq_pkg::ID_W-1:0]       result_id,
    output logic [ptq_pkg::POS_W-1:0]      result_x,
    output logic [ptq_pkg::POS_W-1:0]      result_y,
    output logic [ptq_pkg::TILE_W-1:0]     result_tile
);
    import ptq_pkg::*;

    localparam int PW = $clog2(CAPACITY + 1);
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int ZW = 18 + $clog2(ZONE_SIDE + 1);
    localparam logic [PW-1:0] NIL = PW'(CAPACITY);
    localparam logic signed [ZW-1:0] ZS = ZW'(ZONE_SIDE);

    // Latched request
    logic [OP_W-1:0]   op_reg;
    logic [POS_W-1:0]  px_reg, py_reg;
    logic [TILE_W-1:0] tile_reg;
    logic [ID_W-1:0]   id_reg;
    logic signed [ZW-1:0] zxmin_reg, zxmax_reg, zymin_reg, zymax_reg;
    logic signed [ZW-1:0] zxmin_next, zymin_next;

    // List state
    logic [PW-1:0] head_reg, head_next, tail_reg, tail_next;
    logic [PW-1:0] free_reg, free_next, used_reg, used_next;
    logic [PW-1:0] fresh_reg, fresh_next;
    logic [PW-1:0] cur_reg, cur_next, prev_reg, prev_next;
    logic [PW-1:0] steps_reg, steps_next;
    logic [ST_W-1:0] status_reg, status_next;

    // Memories
    logic [POS_W-1:0]  x_mem [CAPACITY];
    logic [POS_W-1:0]  y_mem [CAPACITY];
    logic [TILE_W-1:0] t_mem [CAPACITY];
    logic [PW-1:0]     link_mem [CAPACITY];
    logic [1:0]        role_mem [CAPACITY];
    logic [POS_W-1:0]  x_rd, y_rd;
    logic [TILE_W-1:0] t_rd;
    logic [PW-1:0]     link_rd;
    logic [1:0]        role_rd;

    logic          xyt_we, link_we, role_we;
    logic [PW-1:0] link_wa, link_wd, role_wa, rd_ptr;
    logic [1:0]    role_wd;
    logic [PW-1:0] id_ptr;
    logic [1:0]    role_eff;
    logic signed [ZW-1:0] ex, ey;
    logic          zone_hit;

    // Output register
    logic              out_valid_reg;
    logic [ST_W-1:0]   out_st_reg;
    logic [ID_W-1:0]   out_id_reg;
    logic [POS_W-1:0]  out_x_reg, out_y_reg;
    logic [TILE_W-1:0] out_t_reg;

    assign id_ptr = PW'(id_reg);

    // Zone bounds from the request
    assign zxmin_next = $signed({{(ZW-ZN_W){zone_x[ZN_W-1]}}, zone_x}) * ZS;
    assign zymin_next = $signed({{(ZW-ZN_W){zone_y[ZN_W-1]}}, zone_y}) * ZS;

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg    <= opcode;
            px_reg    <= pos_x;
            py_reg    <= pos_y;
            tile_reg  <= tile;
            id_reg    <= entry_id;
            zxmin_reg <= zxmin_next;
            zxmax_reg <= zxmin_next + ZS;
            zymin_reg <= zymin_next;
            zymax_reg <= zymin_next + ZS;
        end
    end

    // Shared read address
    always_comb
    begin
        unique case (cmd.rd_sel)
            RD_FREE: rd_ptr = free_reg;
            RD_HEAD: rd_ptr = head_reg;
            RD_ID:   rd_ptr = id_ptr;
            RD_NEXT: rd_ptr = link_rd;
            default: rd_ptr = cur_reg;
        endcase
    end

    // Memories, registered read
    always_ff @(posedge clk)
    begin
        if (xyt_we)
        begin
            x_mem[free_reg[AW-1:0]] <= px_reg;
            y_mem[free_reg[AW-1:0]] <= py_reg;
            t_mem[free_reg[AW-1:0]] <= tile_reg;
        end
        x_rd <= x_mem[rd_ptr[AW-1:0]];
        y_rd <= y_mem[rd_ptr[AW-1:0]];
        t_rd <= t_mem[rd_ptr[AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (link_we)
            link_mem[link_wa[AW-1:0]] <= link_wd;
        link_rd <= link_mem[rd_ptr[AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (role_we)
            role_mem[role_wa[AW-1:0]] <= role_wd;
        role_rd <= role_mem[rd_ptr[AW-1:0]];
    end

    // Match logic on the entry read at cur
    assign ex = $signed({{(ZW-POS_W){x_rd[POS_W-1]}}, x_rd});
    assign ey = $signed({{(ZW-POS_W){y_rd[POS_W-1]}}, y_rd});
    assign zone_hit = (ex >= zxmin_reg) && (ex < zxmax_reg) &&
                      (ey >= zymin_reg) && (ey < zymax_reg);

    // Entries never handed out of the initial free chain are free
    assign role_eff = (cur_reg >= fresh_reg) ? ROLE_FREE : role_rd;

    always_comb
    begin
        stat.op          = op_reg;
        stat.full        = (used_reg == NIL) || (free_reg == NIL);
        stat.head_nil    = (head_reg == NIL);
        stat.id_bad      = 32'(id_reg) >= 32'(CAPACITY);
        stat.used_zero   = (used_reg == '0);
        stat.role_owned  = (role_eff == ROLE_OWNED);
        stat.role_queued = (role_eff == ROLE_QUEUED);
        stat.walk_end    = (link_rd == NIL) || (steps_reg + PW'(1) == NIL);
        stat.out_busy    = out_valid_reg && !rsp_ready;
        case (op_reg)
            OP_ZONE:   stat.match = zone_hit;
            OP_FIND:   stat.match = (x_rd == px_reg) && (y_rd == py_reg);
            OP_REMOVE: stat.match = (cur_reg == id_ptr);
            default:   stat.match = 1'b0;
        endcase
    end

    // List updates
    always_comb
    begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        free_next   = free_reg;
        used_next   = used_reg;
        fresh_next  = fresh_reg;
        cur_next    = cur_reg;
        prev_next   = prev_reg;
        steps_next  = steps_reg;
        status_next = status_reg;
        xyt_we      = 1'b0;
        link_we     = 1'b0;
        link_wa     = cur_reg;
        link_wd     = NIL;
        role_we     = 1'b0;
        role_wa     = cur_reg;
        role_wd     = ROLE_FREE;

        if (cmd.walk_start)
        begin
            cur_next   = head_reg;
            prev_next  = NIL;
            steps_next = '0;
        end
        if (cmd.walk_step)
        begin
            prev_next  = cur_reg;
            cur_next   = link_rd;
            steps_next = steps_reg + PW'(1);
        end
        if (cmd.cur_id)
            cur_next = id_ptr;

        // Take the free head, store the task
        if (cmd.add_commit)
        begin
            xyt_we   = 1'b1;
            link_we  = 1'b1;
            link_wa  = free_reg;
            link_wd  = NIL;
            role_we  = 1'b1;
            role_wa  = free_reg;
            role_wd  = ROLE_QUEUED;
            cur_next = free_reg;
            used_next = used_reg + PW'(1);
            if (free_reg == fresh_reg)
            begin
                free_next  = free_reg + PW'(1);
                fresh_next = fresh_reg + PW'(1);
            end
            else
                free_next = link_rd;
        end

        // Append cur at the tail
        if (cmd.add_link)
        begin
            if (tail_reg != NIL)
            begin
                link_we = 1'b1;
                link_wa = tail_reg;
                link_wd = cur_reg;
            end
            else
                head_next = cur_reg;
            tail_next = cur_reg;
        end

        // Bypass cur; link_rd holds its successor
        if (cmd.unlink)
        begin
            if (prev_reg == NIL)
                head_next = link_rd;
            else
            begin
                link_we = 1'b1;
                link_wa = prev_reg;
                link_wd = link_rd;
            end
            if (tail_reg == cur_reg)
                tail_next = prev_reg;
        end

        if (cmd.own_cur)
        begin
            link_we = 1'b1;
            link_wa = cur_reg;
            link_wd = NIL;
            role_we = 1'b1;
            role_wa = cur_reg;
            role_wd = ROLE_OWNED;
        end

        // Push cur on the free list
        if (cmd.free_cur)
        begin
            link_we   = 1'b1;
            link_wa   = cur_reg;
            link_wd   = free_reg;
            role_we   = 1'b1;
            role_wa   = cur_reg;
            role_wd   = ROLE_FREE;
            free_next = cur_reg;
            used_next = used_reg - PW'(1);
        end

        if (cmd.set_status)
            status_next = cmd.status;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg   <= NIL;
            tail_reg   <= NIL;
            free_reg   <= '0;
            used_reg   <= '0;
            fresh_reg  <= '0;
            cur_reg    <= NIL;
            prev_reg   <= NIL;
            steps_reg  <= '0;
            status_reg <= ST_OK;
        end
        else
        begin
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            free_reg   <= free_next;
            used_reg   <= used_next;
            fresh_reg  <= fresh_next;
            cur_reg    <= cur_next;
            prev_reg   <= prev_next;
            steps_reg  <= steps_next;
            status_reg <= status_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (rsp_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_st_reg <= status_reg;
            if (status_reg == ST_OK)
            begin
                out_id_reg <= ID_W'(cur_reg);
                out_x_reg  <= x_rd;
                out_y_reg  <= y_rd;
                out_t_reg  <= t_rd;
            end
            else
            begin
                out_id_reg <= '0;
                out_x_reg  <= '0;
                out_y_reg  <= '0;
                out_t_reg  <= '0;
            end
        end
    end

    assign rsp_valid   = out_valid_reg;
    assign status      = out_st_reg;
    assign result_id   = out_id_reg;
    assign result_x    = out_x_reg;
    assign result_y    = out_y_reg;
    assign result_tile = out_t_reg;

endmodule

// ----- hw/rtl/ptq_ctrl.sv -----
// Controller: sequences each operation over the datapath.
// Depends on ptq_pkg; drives ptq_datapath through ptq_cmd_t.
module ptq_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  ptq_pkg::ptq_stat_t stat,
    output ptq_pkg::ptq_cmd_t  cmd
);
    import ptq_pkg::*;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DISP     = 4'd1;
    localparam logic [3:0] S_ADD_WR   = 4'd2;
    localparam logic [3:0] S_ADD_LINK = 4'd3;
    localparam logic [3:0] S_TAKE     = 4'd4;
    localparam logic [3:0] S_ROLE     = 4'd5;
    localparam logic [3:0] S_WALK     = 4'd6;
    localparam logic [3:0] S_UNLINK   = 4'd7;
    localparam logic [3:0] S_FETCH    = 4'd8;
    localparam logic [3:0] S_OUT      = 4'd9;

    logic [3:0] state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign req_ready = (state_reg == S_IDLE);

    // Finish with a status and go fetch the result entry
    function automatic ptq_cmd_t finish(input ptq_cmd_t c, input logic [ST_W-1:0] st);
        ptq_cmd_t r;
        r            = c;
        r.set_status = 1'b1;
        r.status     = st;
        return r;
    endfunction

    always_comb
    begin
        cmd        = '0;
        cmd.rd_sel = RD_CUR;
        state_next = state_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_DISP;
                end
            end

            S_DISP:
            begin
                state_next = S_FETCH;
                case (stat.op) inside
                    OP_ADD:
                    begin
                        if (stat.full)
                            cmd = finish(cmd, ST_FULL);
                        else
                        begin
                            cmd.rd_sel = RD_FREE;
                            state_next = S_ADD_WR;
                        end
                    end
                    OP_TAKE, OP_ZONE:
                    begin
                        if (stat.head_nil)
                            cmd = finish(cmd, ST_EMPTY);
                        else
                        begin
                            cmd.walk_start = 1'b1;
                            cmd.rd_sel     = RD_HEAD;
                            state_next     = (stat.op == OP_TAKE) ? S_TAKE : S_WALK;
                        end
                    end
                    OP_FIND:
                    begin
                        if (stat.head_nil)
                            cmd = finish(cmd, ST_NOTFOUND);
                        else
                        begin
                            cmd.walk_start = 1'b1;
                            cmd.rd_sel     = RD_HEAD;
                            state_next     = S_WALK;
                        end
                    end
                    OP_RELEASE:
                    begin
                        if (stat.used_zero)
                            cmd = finish(cmd, ST_EMPTY);
                        else if (stat.id_bad)
                            cmd = finish(cmd, ST_NOTFOUND);
                        else
                        begin
                            cmd.cur_id = 1'b1;
                            cmd.rd_sel = RD_ID;
                            state_next = S_ROLE;
                        end
                    end
                    OP_REMOVE:
                    begin
                        if (stat.id_bad)
                            cmd = finish(cmd, ST_NOTFOUND);
                        else
                        begin
                            cmd.cur_id = 1'b1;
                            cmd.rd_sel = RD_ID;
                            state_next = S_ROLE;
                        end
                    end
                    OP_READ:
                    begin
                        if (stat.id_bad)
                            cmd = finish(cmd, ST_NOTFOUND);
                        else
                        begin
                            cmd.cur_id = 1'b1;
                            cmd = finish(cmd, ST_OK);
                        end
                    end
                    default: cmd = finish(cmd, ST_NOTFOUND);
                endcase
            end

            S_ADD_WR:
            begin
                cmd.add_commit = 1'b1;
                cmd            = finish(cmd, ST_OK);
                state_next     = S_ADD_LINK;
            end

            S_ADD_LINK:
            begin
                cmd.add_link = 1'b1;
                state_next   = S_FETCH;
            end

            // Head removal: prev is none after the walk start
            S_TAKE:
            begin
                cmd.unlink = 1'b1;
                state_next = S_UNLINK;
            end

            S_ROLE:
            begin
                state_next = S_FETCH;
                if (stat.op == OP_RELEASE)
                begin
                    if (stat.role_owned)
                    begin
                        cmd.free_cur = 1'b1;
                        cmd = finish(cmd, ST_OK);
                    end
                    else
                        cmd = finish(cmd, ST_NOTFOUND);
                end
                else if (stat.role_queued)
                begin
                    cmd.walk_start = 1'b1;
                    cmd.rd_sel     = RD_HEAD;
                    state_next     = S_WALK;
                end
                else
                    cmd = finish(cmd, ST_NOTFOUND);
            end

            // One queued entry per cycle; the next read is issued from the link just read
            S_WALK:
            begin
                if (stat.match)
                begin
                    if (stat.op == OP_FIND)
                    begin
                        cmd        = finish(cmd, ST_OK);
                        state_next = S_FETCH;
                    end
                    else
                    begin
                        cmd.unlink = 1'b1;
                        state_next = S_UNLINK;
                    end
                end
                else if (stat.walk_end)
                begin
                    cmd        = finish(cmd, (stat.op == OP_ZONE) ? ST_EMPTY : ST_NOTFOUND);
                    state_next = S_FETCH;
                end
                else
                begin
                    cmd.walk_step = 1'b1;
                    cmd.rd_sel    = RD_NEXT;
                end
            end

            S_UNLINK:
            begin
                if (stat.op == OP_REMOVE)
                    cmd.free_cur = 1'b1;
                else
                    cmd.own_cur = 1'b1;
                cmd        = finish(cmd, ST_OK);
                state_next = S_FETCH;
            end

            S_FETCH:
            begin
                state_next = S_OUT;
            end

            S_OUT:
            begin
                if (!stat.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

endmodule
